/* design/lfmd_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// lfmd_pkg
// Shared widths, field offsets, codes and the control bundle of the limb
// fast-motion detector.
// -----------------------------------------------------------------------------
package lfmd_pkg;

  localparam int IDX_W   = 5;
  localparam int POS_W   = 18;
  localparam int TS_W    = 32;
  localparam int IVL_W   = 16;
  localparam int THR_W   = 24;
  localparam int ENTRY_W = 3 * POS_W + TS_W;

  localparam int SQ_W    = 2 * POS_W;          // one axis squared
  localparam int D2_W    = SQ_W + 2;           // sum of three squares
  localparam int LHS_W   = D2_W + 16;          // d2 * 65536
  localparam int P_W     = THR_W + IVL_W;      // threshold * dt
  localparam int PLIM_W  = LHS_W / 2;          // p at or above 2^27 is never fast

  localparam int NUM_SENSORS_DEF = 32;

  // input item packing, lowest bit first
  localparam int IDX_LSB     = 0;
  localparam int X_LSB       = IDX_LSB + IDX_W;
  localparam int TS_LSB      = X_LSB + 3 * POS_W;
  localparam int S_TDATA_W   = ((TS_LSB + TS_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR     = 2'd2;

  localparam logic [IVL_W-1:0] MIN_IVL_RST = 16'd50;
  localparam logic [IVL_W-1:0] MAX_IVL_RST = 16'd500;
  localparam logic [THR_W-1:0] THR_RST     = 24'd1573;

  typedef enum logic [1:0] {
    OUT_FIRST = 2'd0,
    OUT_SOON  = 2'd1,
    OUT_REARM = 2'd2,
    OUT_EVAL  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic load_in;   // item accepted, table read issued
    logic stage1;    // dt, axis squares, threshold product
    logic stage2;    // square sum, product squared
    logic finish;    // commit entry, load result register
  } lfmd_cmd_t;

endpackage
`default_nettype wire

/* design/lfmd_ram.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// lfmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module lfmd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire                                         clk_i,
  input  wire                                         we_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire  [Width-1:0]                            wdata_i,
  input  wire                                         re_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/lfmd_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// lfmd_ctrl
// Sequencer: accepts one item, steps it through the datapath and hands the
// result to the output register, which drains independently.
// -----------------------------------------------------------------------------
module lfmd_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  wire                 m_tready_i,
  output lfmd_pkg::lfmd_cmd_t cmd_o
);
  import lfmd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EX1  = 2'd1;
  localparam logic [1:0] ST_EX2  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       finish;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  // result slot is free or is emptied in this same cycle
  assign finish     = (state_q == ST_FIN) && (!out_valid_q || m_tready_i);
  assign m_tvalid_o = out_valid_q;

  assign cmd_o.load_in = accept;
  assign cmd_o.stage1  = (state_q == ST_EX1);
  assign cmd_o.stage2  = (state_q == ST_EX2);
  assign cmd_o.finish  = finish;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EX1;
      ST_EX1:  state_d = ST_EX2;
      ST_EX2:  state_d = ST_FIN;
      ST_FIN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_tready_o)
    else $error("item accepted while previous one still in flight");

  a_fin_three_later: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 (state_q == ST_FIN))
    else $error("sequencer did not reach finish three cycles after accept");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !finish) |=> (state_q == ST_FIN && out_valid_q))
    else $error("finished result left while output register was full");
`endif

endmodule
`default_nettype wire

/* design/lfmd_dp.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// lfmd_dp
// Datapath: configuration registers, per-sensor table (seen bits in flops,
// position and time in RAM), speed arithmetic and the result register.
// -----------------------------------------------------------------------------
module lfmd_dp #(
  parameter int NumSensors = lfmd_pkg::NUM_SENSORS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  lfmd_pkg::lfmd_cmd_t                 cmd_i,
  input  wire                                 cfg_we_i,
  input  wire  [lfmd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [lfmd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire  [lfmd_pkg::S_TDATA_W-1:0]      s_tdata_i,
  output logic [lfmd_pkg::M_TDATA_W-1:0]      m_tdata_o
);
  import lfmd_pkg::*;

  localparam int AddrW = (NumSensors > 1) ? $clog2(NumSensors) : 1;

  // configuration
  logic [IVL_W-1:0] min_ivl_q, max_ivl_q;
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ivl_q <= MIN_IVL_RST;
      max_ivl_q <= MAX_IVL_RST;
      thr_q     <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_IVL: min_ivl_q <= cfg_data_i[IVL_W-1:0];
        CFG_MAX_IVL: max_ivl_q <= cfg_data_i[IVL_W-1:0];
        CFG_THR:     thr_q     <= cfg_data_i[THR_W-1:0];
        default:     ;
      endcase
    end
  end

  // input capture
  logic [IDX_W-1:0]          s_idx;
  logic [AddrW+IDX_W-1:0]    s_idx_ext;
  logic [AddrW-1:0]          s_addr;
  logic [IDX_W-1:0]          idx_q;
  logic [AddrW+IDX_W-1:0]    idx_ext;
  logic [AddrW-1:0]          addr_q;
  logic [3*POS_W-1:0]        pos_q;
  logic [TS_W-1:0]           ts_q;

  assign s_idx     = s_tdata_i[IDX_LSB +: IDX_W];
  assign s_idx_ext = (AddrW + IDX_W)'(s_idx);
  assign s_addr    = s_idx_ext[AddrW-1:0];
  assign idx_ext   = (AddrW + IDX_W)'(idx_q);
  assign addr_q    = idx_ext[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q <= s_idx;
      pos_q <= s_tdata_i[X_LSB +: 3*POS_W];
      ts_q  <= s_tdata_i[TS_LSB +: TS_W];
    end
  end

  // table
  logic [NumSensors-1:0] seen_q;
  logic [ENTRY_W-1:0]    entry_rd;
  logic                  tbl_we;

  lfmd_ram #(
    .Width (ENTRY_W),
    .Depth (NumSensors)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr_q),
    .wdata_i ({ts_q, pos_q}),
    .re_i    (cmd_i.load_in),
    .raddr_i (s_addr),
    .rdata_o (entry_rd)
  );

  // stage 1: elapsed time, classification, axis squares, threshold product
  logic [TS_W-1:0]            dt;
  logic                       in_range;
  outcome_e                   kind_d, kind_q;
  logic signed [POS_W:0]      dax [3];
  logic signed [2*POS_W+1:0]  prod [3];
  logic [2:0][SQ_W-1:0]       sq_q;
  logic [P_W-1:0]             p_q;

  assign dt       = ts_q - entry_rd[3*POS_W +: TS_W];
  assign in_range = 32'(idx_q) < 32'(NumSensors);

  always_comb begin
    priority if (!in_range) begin
      kind_d = OUT_SOON;
    end else if (!seen_q[addr_q]) begin
      kind_d = OUT_FIRST;
    end else if (dt < TS_W'(min_ivl_q)) begin
      kind_d = OUT_SOON;
    end else if (dt > TS_W'(max_ivl_q)) begin
      kind_d = OUT_REARM;
    end else begin
      kind_d = OUT_EVAL;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dax[a]  = $signed({pos_q[a*POS_W + POS_W - 1], pos_q[a*POS_W +: POS_W]})
              - $signed({entry_rd[a*POS_W + POS_W - 1], entry_rd[a*POS_W +: POS_W]});
      prod[a] = dax[a] * dax[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage1) begin
      kind_q <= kind_d;
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= prod[a][SQ_W-1:0];
      end
      // dt fits 16 bits whenever the test is evaluated
      p_q <= P_W'(thr_q) * P_W'(dt[IVL_W-1:0]);
    end
  end

  // stage 2: square sum, product squared
  logic [D2_W-1:0]  d2_q;
  logic [LHS_W-1:0] pp_q;
  logic             p_big_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage2) begin
      d2_q    <= D2_W'(sq_q[0]) + D2_W'(sq_q[1]) + D2_W'(sq_q[2]);
      pp_q    <= LHS_W'(p_q[PLIM_W-1:0]) * LHS_W'(p_q[PLIM_W-1:0]);
      p_big_q <= |p_q[P_W-1:PLIM_W];
    end
  end

  // finish: compare, commit, result
  logic fast;
  logic [LHS_W-1:0] lhs;

  assign lhs    = {d2_q, 16'd0};
  assign fast   = (kind_q == OUT_EVAL) && !p_big_q && (lhs > pp_q);
  assign tbl_we = cmd_i.finish && (kind_q != OUT_SOON);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (tbl_we) begin
      seen_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_tdata_o <= {(M_TDATA_W - 3)'(0), kind_q, fast};
    end
  end

endmodule
`default_nettype wire

/* design/limb_fast_motion_detector.sv */
// Each accepted item is walked by the sequencer through the table read, two arithmetic
//   stages and the table write-back, which also loads the result once the output is free;
//   no new item is accepted until the previous one has finished.
// The finished result sits in an output register; the next item is taken meanwhile.
// Reset (rst_ni, async, active low) clears all seen marks at once and loads the
//   register defaults; no clearing pass is needed.
`default_nettype none
// -----------------------------------------------------------------------------
// limb_fast_motion_detector
// Per-sensor speed check on tracker samples with min/max interval gating.
// -----------------------------------------------------------------------------
module limb_fast_motion_detector #(
  parameter int NumSensors = lfmd_pkg::NUM_SENSORS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // config: index 0 min_interval_ms, 1 max_interval_ms, 2 speed_threshold
  input  wire                              cfg_we_i,
  input  wire  [lfmd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [lfmd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // sensor_index[4:0], pos_x[22:5], pos_y[40:23], pos_z[58:41], timestamp_ms[90:59]
  input  wire  [lfmd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // fast_motion[0], outcome[2:1]
  output logic [lfmd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import lfmd_pkg::*;

  lfmd_cmd_t cmd;

  lfmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  lfmd_dp #(
    .NumSensors (NumSensors)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* sim/limb_fast_motion_detector_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// limb_fast_motion_detector_tb
// Drives tracker samples into the detector and checks each verdict against a
// per-sensor speed predictor. Directed cases cover interval gating, wrap, the
// threshold boundary and extreme registers. Random traffic then runs under
// several register settings with random sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module limb_fast_motion_detector_tb;
  import lfmd_pkg::*;

  localparam int NUM_SENSORS = NUM_SENSORS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned P_LIMIT = 64'd1 << 27;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TS_W-1:0]         t;
    bit                      seen;
  } sensor_entry_t;

  typedef struct {
    bit       fast;
    outcome_e outcome;
  } verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // sensor_index, pos_x, pos_y, pos_z, timestamp_ms
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // fast_motion, outcome
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  limb_fast_motion_detector #(
    .NumSensors(NUM_SENSORS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  sensor_entry_t    sensor_tbl[NUM_SENSORS];
  logic [IVL_W-1:0] min_ivl = MIN_IVL_RST;
  logic [IVL_W-1:0] max_ivl = MAX_IVL_RST;
  logic [THR_W-1:0] thr     = THR_RST;
  verdict_t         pending_verdicts[$];

  // traffic shaping
  int burst_left   = 0;
  int tx_gap_max   = 6;
  int rx_stall_pct = 30;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int rx_run_left  = 0;
  bit rx_on        = 1'b1;

  int samples_sent     = 0;
  int verdicts_checked = 0;
  int mismatches       = 0;
  int settings_used    = 1;
  int fast_seen        = 0;
  int outcome_hist[4]  = '{0, 0, 0, 0};

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned axis_sq(logic signed [POS_W-1:0] a,
                                              logic signed [POS_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // Updates the sensor table the way the block does and returns the verdict.
  function automatic verdict_t predict_motion(logic [IDX_W-1:0] sid,
                                              logic signed [POS_W-1:0] x,
                                              logic signed [POS_W-1:0] y,
                                              logic signed [POS_W-1:0] z,
                                              logic [TS_W-1:0] ts);
    verdict_t          v;
    logic [TS_W-1:0]   dt;
    longint unsigned   d2;
    longint unsigned   p;
    v.fast = 1'b0;
    v.outcome = OUT_SOON;
    if (sid < NUM_SENSORS) begin
      if (!sensor_tbl[sid].seen) begin
        sensor_tbl[sid] = '{x, y, z, ts, 1'b1};
        v.outcome = OUT_FIRST;
      end else begin
        dt = ts - sensor_tbl[sid].t;
        if (dt < min_ivl) begin
          v.outcome = OUT_SOON;
        end else if (dt > max_ivl) begin
          sensor_tbl[sid] = '{x, y, z, ts, 1'b1};
          v.outcome = OUT_REARM;
        end else begin
          d2 = axis_sq(x, sensor_tbl[sid].x) + axis_sq(y, sensor_tbl[sid].y) +
               axis_sq(z, sensor_tbl[sid].z);
          p = 64'(thr) * 64'(dt);
          // p past 2^27 squares beyond any reachable distance term
          v.fast = (p < P_LIMIT) && ((d2 << 16) > p * p);
          sensor_tbl[sid] = '{x, y, z, ts, 1'b1};
          v.outcome = OUT_EVAL;
        end
      end
    end
    return v;
  endfunction

  // Call at a rising edge with the block idle.
  task automatic program_regs(input logic [IVL_W-1:0] mn, input logic [IVL_W-1:0] mx,
                              input logic [THR_W-1:0] th, input bit with_unused);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MIN_IVL;
    cfg_data_i  <= {8'($urandom), mn};  // upper bits must be dropped
    min_ivl = mn;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_IVL;
    cfg_data_i  <= {8'($urandom), mx};
    max_ivl = mx;
    @(posedge clk_i);
    cfg_index_i <= CFG_THR;
    cfg_data_i  <= th;
    thr = th;
    @(posedge clk_i);
    if (with_unused) begin
      cfg_index_i <= CFG_UNUSED;
      cfg_data_i  <= CFG_DATA_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(input logic [IDX_W-1:0] sid, input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z, input logic [TS_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      if (tx_gap_max > 0) begin
        gap = $urandom_range(1, tx_gap_max);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({ts, z, y, x, sid});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(predict_motion(sid, x, y, z, ts));
    samples_sent++;
    burst_left--;
  endtask

  // Mostly plausible follow-up samples with speeds around the threshold,
  // plus gating misses and pure noise.
  task automatic send_random_sample();
    int              sid;
    int              kind;
    int              span;
    logic [TS_W-1:0] dt;
    logic [TS_W-1:0] ts;
    longint unsigned reach;
    logic signed [POS_W-1:0] px, py, pz;
    sid  = $urandom_range(0, NUM_SENSORS - 1);
    kind = $urandom_range(0, 99);
    if (!sensor_tbl[sid].seen || kind < 8) begin
      ts = $urandom;
      px = POS_W'($urandom);
      py = POS_W'($urandom);
      pz = POS_W'($urandom);
    end else begin
      if (kind < 72)      dt = $urandom_range(min_ivl, max_ivl);
      else if (kind < 82) dt = (min_ivl == 0) ? '0 : $urandom_range(0, min_ivl - 1);
      else if (kind < 92) dt = max_ivl + 1 + $urandom_range(0, 3000);
      else                dt = $urandom;
      reach = (64'(thr) * 64'(dt)) >> 8;
      span = (reach > 131071) ? 131071 : ((reach < 2) ? 2 : int'(reach));
      ts = sensor_tbl[sid].t + dt;
      px = POS_W'(int'(sensor_tbl[sid].x) + int'($urandom_range(0, 2 * span)) - span);
      py = POS_W'(int'(sensor_tbl[sid].y) + int'($urandom_range(0, 2 * span)) - span);
      pz = POS_W'(int'(sensor_tbl[sid].z) + int'($urandom_range(0, 2 * span)) - span);
    end
    send_sample(IDX_W'(sid), px, py, pz, ts);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // reset registers: first sample, too soon, both interval edges, re-arm,
  // time going back and timestamp wrap
  task automatic test_sample_gating();
    send_sample(5'd0, -18'sd131072, 18'sd131071, 18'sd0, 32'd1000);
    send_sample(5'd0, 18'sd0, 18'sd0, 18'sd0, 32'd1049);
    send_sample(5'd0, 18'sd131071, -18'sd131072, -18'sd1, 32'd1050);
    send_sample(5'd0, 18'sd131071, -18'sd131072, -18'sd1, 32'd1550);
    send_sample(5'd0, 18'sd5, 18'sd5, 18'sd5, 32'd2051);
    send_sample(5'd0, 18'sd5, 18'sd5, 18'sd5, 32'd2000);
    send_sample(5'd31, 18'sd1, 18'sd2, 18'sd3, 32'hFFFF_FFF0);
    send_sample(5'd31, 18'sd100, -18'sd100, 18'sd50, 32'h0000_0050);
    send_sample(5'd31, 18'sd100, -18'sd100, 18'sd50, 32'h0000_0050);
    wait_results_drained();
  endtask

  // threshold 1.0 LSB/ms: exactly on the limit is slow, one LSB more is fast
  task automatic test_speed_boundary();
    program_regs(16'd0, 16'd65535, 24'd256, 1'b0);
    send_sample(5'd2, 18'sd0, 18'sd0, 18'sd0, 32'd5000);
    send_sample(5'd2, 18'sd100, 18'sd0, 18'sd0, 32'd5100);
    send_sample(5'd2, 18'sd201, 18'sd0, 18'sd0, 32'd5200);
    send_sample(5'd2, 18'sd201, 18'sd0, 18'sd0, 32'd5200);
    send_sample(5'd2, 18'sd202, 18'sd0, 18'sd0, 32'd5200);
    send_sample(5'd2, 18'sd202, -18'sd100, 18'sd0, 32'd5300);
    send_sample(5'd2, 18'sd202, -18'sd100, -18'sd101, 32'd5400);
    wait_results_drained();
  endtask

  // maximal threshold, min above max, and all-zero registers
  task automatic test_config_extremes();
    program_regs(16'd0, 16'd65535, 24'hFF_FFFF, 1'b1);
    send_sample(5'd3, -18'sd131072, -18'sd131072, -18'sd131072, 32'd0);
    send_sample(5'd3, 18'sd131071, 18'sd131071, 18'sd131071, 32'd65535);
    send_sample(5'd3, -18'sd131072, -18'sd131072, -18'sd131072, 32'd65543);
    wait_results_drained();
    program_regs(16'd1000, 16'd10, 24'd0, 1'b0);
    send_sample(5'd3, 18'sd0, 18'sd0, 18'sd0, 32'd66043);
    send_sample(5'd3, 18'sd0, 18'sd0, 18'sd0, 32'd68043);
    wait_results_drained();
    program_regs(16'd0, 16'd0, 24'd0, 1'b0);
    send_sample(5'd4, 18'sd7, 18'sd7, 18'sd7, 32'd7);
    send_sample(5'd4, 18'sd8, 18'sd7, 18'sd7, 32'd7);
    send_sample(5'd4, 18'sd8, 18'sd7, 18'sd7, 32'd7);
    send_sample(5'd4, 18'sd8, 18'sd7, 18'sd7, 32'd8);
    wait_results_drained();
  endtask

  // output held off long enough to back up into the input
  task automatic test_backpressure();
    program_regs(16'd50, 16'd500, 24'd1573, 1'b0);
    tx_gap_max = 0;
    @(negedge clk_i);
    rx_hold_req = 200;
    @(posedge clk_i);
    repeat (40) send_random_sample();
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n, input logic [IVL_W-1:0] mn,
                                     input logic [IVL_W-1:0] mx, input logic [THR_W-1:0] th,
                                     input int gap_max, input int stall_pct);
    program_regs(mn, mx, th, 1'b0);
    tx_gap_max = gap_max;
    rx_stall_pct = stall_pct;
    repeat (n) send_random_sample();
    wait_results_drained();
  endtask

  // verdict checker and receiver stall pattern
  always @(posedge clk_i) begin
    verdict_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict item with none pending, tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          exp = pending_verdicts.pop_front();
          if (m_axis_tdata[0] !== exp.fast) begin
            $error("fast_motion: expected %0d, actual %0d", exp.fast, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[2:1] !== exp.outcome) begin
            $error("outcome: expected %0d, actual %0d", exp.outcome, m_axis_tdata[2:1]);
            mismatches++;
          end
          outcome_hist[int'(exp.outcome)]++;
          if (exp.fast) fast_seen++;
          verdicts_checked++;
        end
      end
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_run_left == 0) begin
          rx_on = (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
          rx_run_left = $urandom_range(1, 6);
        end
        rx_run_left--;
        m_axis_tready <= rx_on;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_gating();
    test_speed_boundary();
    test_config_extremes();
    test_backpressure();
    test_random_traffic(295, 16'd50, 16'd500, 24'd1573, 6, 30);
    test_random_traffic(295, 16'd0, 16'd65535, 24'd0, 0, 0);
    test_random_traffic(295, 16'd65535, 16'd65535, 24'hFF_FFFF, 3, 60);
    test_random_traffic(295, 16'd1000, 16'd10, THR_W'($urandom), 8, 10);
    test_random_traffic(295, 16'($urandom_range(0, 300)), 16'($urandom_range(300, 5000)),
                        THR_W'($urandom_range(0, 20000)), 4, 40);
    test_random_traffic(295, 16'd10, 16'd200, 24'd100000, 2, 20);

    wait_results_drained();
    $display("%0d samples over %0d register settings, %0d verdicts checked",
             samples_sent, settings_used, verdicts_checked);
    $display("first %0d, too soon %0d, re-armed %0d, evaluated %0d (%0d fast)",
             outcome_hist[0], outcome_hist[1], outcome_hist[2], outcome_hist[3], fast_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
